### hw/rtl/dab_dual_phase_shift_inner_duty_assert.svh
// Assertion macros for the inner duty solver.
`ifndef DAB_DUAL_PHASE_SHIFT_INNER_DUTY_ASSERT_SVH
`define DAB_DUAL_PHASE_SHIFT_INNER_DUTY_ASSERT_SVH
// Implication checked on every clock, off during reset.
`define DAB_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
// Next-cycle implication.
`define DAB_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

### hw/rtl/dab_pkg.sv
// Shared constants and types of the inner duty solver.
package dab_pkg;
  localparam int unsigned DutyFracBits = 14;
  localparam logic [16:0] KOne = 17'd65536;
  localparam logic [16:0] KMin = 17'd66;

  typedef enum logic [2:0] {
    REG_TURNS = 3'd0, REG_GAIN = 3'd1, REG_U2MIN = 3'd2, REG_PNMIN = 3'd3,
    REG_D2LO = 3'd4, REG_D2HI = 3'd5, REG_D1LO = 3'd6, REG_D1HI = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    TRAJ_NONE = 3'd0, TRAJ_R1 = 3'd1, TRAJ_R2 = 3'd2, TRAJ_R3 = 3'd3, TRAJ_R4 = 3'd4
  } traj_e;

  typedef struct packed {
    logic [15:0] turns;
    logic [31:0] gain;
    logic [15:0] u2_min;
    logic [19:0] pn_min;
    logic signed [15:0] d2_lo;
    logic signed [15:0] d2_hi;
    logic signed [15:0] d1_lo;
    logic signed [15:0] d1_hi;
  } cfg_t;
endpackage

### hw/rtl/dab_if.sv
// Valid/ready channel interfaces for the inner duty solver.
interface dab_in_if;
  logic valid;
  logic ready;
  logic [15:0] primary_volts;
  logic [15:0] secondary_volts;
  logic signed [15:0] secondary_amps;
  logic signed [15:0] outer_duty;
  modport source (output valid, primary_volts, secondary_volts, secondary_amps,
                  outer_duty, input ready);
  modport sink (input valid, primary_volts, secondary_volts, secondary_amps,
                outer_duty, output ready);
endinterface

interface dab_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] inner_duty;
  logic signed [15:0] outer_duty_used;
  logic [2:0] trajectory;
  logic [6:0] error_bits;
  logic [16:0] voltage_ratio;
  logic [16:0] load_fraction;
  logic [19:0] base_power;
  modport source (output valid, inner_duty, outer_duty_used, trajectory, error_bits,
                  voltage_ratio, load_fraction, base_power, input ready);
  modport sink (input valid, inner_duty, outer_duty_used, trajectory, error_bits,
                voltage_ratio, load_fraction, base_power, output ready);
endinterface

### hw/rtl/dab_cfg.sv
// Configuration register file.
module dab_cfg (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  output dab_pkg::cfg_t cfg_o
);
  dab_pkg::cfg_t cfg_q;
  assign cfg_o = cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.turns  <= 16'd1024;
      cfg_q.gain   <= 32'd6554;
      cfg_q.u2_min <= 16'd640;
      cfg_q.pn_min <= 20'd16;
      cfg_q.d2_lo  <= 16'sd0;
      cfg_q.d2_hi  <= 16'sd16384;
      cfg_q.d1_lo  <= 16'sd0;
      cfg_q.d1_hi  <= 16'sd16384;
    end else if (cfg_we_i) begin
      unique case (dab_pkg::reg_idx_e'(cfg_idx_i))
        dab_pkg::REG_TURNS: cfg_q.turns  <= cfg_data_i[15:0];
        dab_pkg::REG_GAIN:  cfg_q.gain   <= cfg_data_i;
        dab_pkg::REG_U2MIN: cfg_q.u2_min <= cfg_data_i[15:0];
        dab_pkg::REG_PNMIN: cfg_q.pn_min <= cfg_data_i[19:0];
        dab_pkg::REG_D2LO:  cfg_q.d2_lo  <= cfg_data_i[15:0];
        dab_pkg::REG_D2HI:  cfg_q.d2_hi  <= cfg_data_i[15:0];
        dab_pkg::REG_D1LO:  cfg_q.d1_lo  <= cfg_data_i[15:0];
        default:            cfg_q.d1_hi  <= cfg_data_i[15:0];
      endcase
    end
  end
endmodule

### hw/rtl/dab_divider.sv
// Pipelined restoring divider, one quotient bit per stage, stall aware.
module dab_divider #(
  parameter int unsigned NumW = 48,
  parameter int unsigned DenW = 32,
  parameter int unsigned TagW = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  input  logic [TagW-1:0] tag_i,
  output logic            valid_o,
  output logic [NumW-1:0] quo_o,
  output logic [TagW-1:0] tag_o
);
  logic [NumW:0]          vld_q;
  logic [NumW-1:0]        quo_q [NumW+1];
  logic [DenW:0]          rem_q [NumW+1];
  logic [DenW-1:0]        den_q [NumW+1];
  logic [TagW-1:0]        tag_q [NumW+1];

  assign vld_q[0] = valid_i;
  assign quo_q[0] = num_i;
  assign rem_q[0] = '0;
  assign den_q[0] = den_i;
  assign tag_q[0] = tag_i;

  // each stage shifts one numerator bit into the remainder
  for (genvar s = 0; s < NumW; s++) begin : g_st
    logic [DenW+1:0] trial;
    logic [DenW:0]   rem_sh;
    logic            take;
    assign rem_sh = {rem_q[s][DenW-1:0], quo_q[s][NumW-1]};
    assign trial  = {1'b0, rem_sh} - {2'b0, den_q[s]};
    assign take   = ~trial[DenW+1];
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[s+1] <= 1'b0;
      else if (en_i) vld_q[s+1] <= vld_q[s];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1] <= take ? trial[DenW:0] : rem_sh;
        quo_q[s+1] <= {quo_q[s][NumW-2:0], take};
        den_q[s+1] <= den_q[s];
        tag_q[s+1] <= tag_q[s];
      end
    end
  end

  assign valid_o = vld_q[NumW];
  assign quo_o   = quo_q[NumW];
  assign tag_o   = tag_q[NumW];
endmodule

### hw/rtl/dab_dual_phase_shift_inner_duty.sv
// Inner duty solver for a dual-active-bridge converter: a fully pipelined datapath
// that accepts one item per clock while its output is not stalled. Its depth is
// set by two chained bit-per-stage dividers (K and p0 side by side, 40 stages, then
// D1, 47 stages) plus ten register stages. While a result waits unaccepted the whole
// pipeline holds and the input is refused; nothing is lost. Configuration is to be
// written by the user only while idle; the block itself does not enforce it.
module dab_dual_phase_shift_inner_duty #(
  parameter int unsigned DUTY_FRAC_BITS = dab_pkg::DutyFracBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  dab_in_if.sink      in_if,
  dab_out_if.source   out_if
);
  `include "dab_dual_phase_shift_inner_duty_assert.svh"
  localparam int unsigned DW = DUTY_FRAC_BITS + 10;
  localparam int signed   One = 1 <<< DUTY_FRAC_BITS;

  dab_pkg::cfg_t cfg;
  dab_cfg u_cfg (.clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .cfg_o(cfg));

  // whole pipeline advances when output register is free
  logic en;
  assign en = !out_if.valid || out_if.ready;
  assign in_if.ready = en;

  // carried per-item context
  typedef struct packed {
    logic [15:0]        u1;
    logic [15:0]        u2;
    logic [15:0]        ai2;
    logic signed [15:0] d2;
    logic [6:0]         flags;
    logic               early;
    logic               pnsm;
    logic [16:0]        k;
    logic [19:0]        pn;
    logic [16:0]        p;
    logic [33:0]        kden;
  } ctx_t;
  localparam int unsigned CW = $bits(ctx_t);

  // stage A: register input, U2 test, D2 clamp, |I2|
  ctx_t a_q; logic a_v_q;
  ctx_t a_d;
  logic signed [15:0] d2c;
  always_comb begin
    a_d = '0;
    a_d.u1 = in_if.primary_volts;
    a_d.u2 = in_if.secondary_volts;
    a_d.ai2 = in_if.secondary_amps[15] ? 16'(-in_if.secondary_amps) :
              16'(in_if.secondary_amps);
    if (in_if.outer_duty < cfg.d2_lo) d2c = cfg.d2_lo;
    else if (in_if.outer_duty > cfg.d2_hi) d2c = cfg.d2_hi;
    else d2c = in_if.outer_duty;
    a_d.d2 = d2c;
    a_d.flags[4] = (d2c != in_if.outer_duty);
    a_d.early = in_if.secondary_volts < cfg.u2_min;
    a_d.kden = 34'(cfg.turns * in_if.secondary_volts);
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a_v_q <= 1'b0;
    else if (en) a_v_q <= in_if.valid;
  end
  always_ff @(posedge clk_i) if (en) a_q <= a_d;

  // stage B: u1*u2 product
  ctx_t b_q; logic b_v_q; logic [31:0] uu_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) b_v_q <= 1'b0;
    else if (en) b_v_q <= a_v_q;
  end
  always_ff @(posedge clk_i) if (en) begin
    b_q <= a_q;
    uu_q <= a_q.u1 * a_q.u2;
  end

  // stage C: gain product, split into halves
  ctx_t c_q; logic c_v_q; logic [47:0] glo_q; logic [47:0] ghi_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) c_v_q <= 1'b0;
    else if (en) c_v_q <= b_v_q;
  end
  always_ff @(posedge clk_i) if (en) begin
    c_q <= b_q;
    glo_q <= 48'(cfg.gain * uu_q[15:0]);
    ghi_q <= 48'(cfg.gain * uu_q[31:16]);
  end

  // stage D: PN, U2*|I2|
  ctx_t e_q; logic e_v_q; logic [31:0] pw_q; ctx_t e_d;
  logic [64:0] gsum; logic [40:0] pnr;
  assign gsum = {1'b0, ghi_q, 16'd0} + 65'(glo_q);
  assign pnr = gsum[64:24];
  always_comb begin
    e_d = c_q;
    e_d.pn = (pnr > 41'hFFFFF) ? 20'hFFFFF : pnr[19:0];
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) e_v_q <= 1'b0;
    else if (en) e_v_q <= c_v_q;
  end
  always_ff @(posedge clk_i) if (en) begin
    e_q <= e_d;
    pw_q <= c_q.u2 * c_q.ai2;
  end

  // K divider: u1<<24 / n*u2
  logic kv; logic [39:0] kq; logic [CW-1:0] kt;
  dab_divider #(.NumW(40), .DenW(34), .TagW(CW)) u_kdiv (
    .clk_i, .rst_ni, .en_i(en), .valid_i(e_v_q), .num_i({e_q.u1, 24'd0}),
    .den_i(e_q.kden), .tag_i(e_q), .valid_o(kv), .quo_o(kq), .tag_o(kt));
  // p0 divider runs alongside, same depth
  logic pv; logic [39:0] pq; logic [31:0] pwt;
  dab_divider #(.NumW(40), .DenW(20), .TagW(32)) u_pdiv (
    .clk_i, .rst_ni, .en_i(en), .valid_i(e_v_q), .num_i({2'b0, pw_q, 6'd0}),
    .den_i(e_q.pn), .tag_i(pw_q), .valid_o(pv), .quo_o(pq), .tag_o(pwt));

  // stage F: clamp K and p0, PN minimum test
  ctx_t f_q; logic f_v_q; ctx_t f_d; ctx_t kt_s;
  assign kt_s = ctx_t'(kt);
  always_comb begin
    f_d = kt_s;
    if (kt_s.kden == '0 || kq > 40'(dab_pkg::KOne)) begin
      f_d.k = dab_pkg::KOne; f_d.flags[1] = 1'b1;
    end else if (kq < 40'(dab_pkg::KMin)) begin
      f_d.k = dab_pkg::KMin; f_d.flags[1] = 1'b1;
    end else f_d.k = kq[16:0];
    f_d.pnsm = kt_s.pn < cfg.pn_min;
    if (kt_s.pn == '0) begin
      f_d.p = (pwt == '0) ? 17'd0 : dab_pkg::KOne;
      f_d.flags[3] = (pwt != '0);
    end else if (pq > 40'(dab_pkg::KOne)) begin
      f_d.p = dab_pkg::KOne; f_d.flags[3] = 1'b1;
    end else f_d.p = pq[16:0];
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) f_v_q <= 1'b0;
    else if (en) f_v_q <= kv;
  end
  always_ff @(posedge clk_i) if (en) f_q <= f_d;

  // stage G: K polynomials
  ctx_t g_q; logic g_v_q;
  logic [33:0] kk_q, ck_q;
  logic [35:0] a1_q, a2_q;
  logic [35:0] c1, c2;
  logic [18:0] k3 ;
  assign k3 = 19'(3 * 65536) - 19'(f_q.k);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) g_v_q <= 1'b0;
    else if (en) g_v_q <= f_v_q;
  end
  always_ff @(posedge clk_i) if (en) begin
    g_q <= f_q;
    kk_q <= 34'(f_q.k * f_q.k);
    a1_q <= 36'(k3 * k3);
    a2_q <= 36'((20'(6 * 65536) + 20'(2 * f_q.k)) * (17'd65536 - f_q.k));
    ck_q <= 34'(f_q.k) << 17;
  end
  always_comb begin
    c1 = 36'(kk_q) + 36'(ck_q) + 36'(3) * 36'h1_0000_0000;
    c2 = 36'(3) * 36'h1_0000_0000 + 36'(ck_q) - 36'(kk_q);
  end

  // stage H: threshold products
  ctx_t h_q; logic h_v_q;
  logic [52:0] la_q, ra_q, lc_q, rc_q; logic [33:0] lb_q, rb_q; logic lowk_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) h_v_q <= 1'b0;
    else if (en) h_v_q <= g_v_q;
  end
  always_ff @(posedge clk_i) if (en) begin
    h_q <= g_q;
    la_q <= 53'(g_q.p * a1_q);
    ra_q <= 53'(a2_q) << 16;
    lb_q <= 34'(g_q.p) << 16;
    rb_q <= 34'h1_0000_0000 - kk_q;
    lc_q <= 53'(g_q.p * c1);
    rc_q <= 53'(c2) << 16;
    lowk_q <= (36'(kk_q) * 36'd3) < 36'h1_0000_0000;
  end

  // stage I: trajectory select, numerator and divisor
  typedef struct packed {
    ctx_t c;
    logic [2:0] traj;
    logic neg;
  } dtag_t;
  localparam int unsigned TW = $bits(dtag_t);
  dtag_t i_q; logic i_v_q; logic signed [47:0] inum_q; logic [19:0] iden_q;
  logic signed [47:0] nm, n1, n4; logic le_a, le_b, le_c; logic [2:0] tr;
  logic [19:0] dv;
  logic signed [23:0] n4s;
  always_comb begin
    le_a = la_q <= ra_q;
    le_b = lb_q <= rb_q;
    le_c = lc_q <= rc_q;
    n1 = (48'(2) * 48'(h_q.d2) - 48'(One)) <<< 16;
    nm = n1 + 48'(signed'({1'b0, h_q.k})) * 48'(One);
    n4 = 48'(2) * 48'(h_q.d2) - 48'(One);
    if (le_a || (lowk_q && le_b)) begin tr = dab_pkg::TRAJ_R1; dv = 20'(h_q.k) + 20'd65536; end
    else if (le_b) begin tr = dab_pkg::TRAJ_R2; dv = 20'd2; nm = 48'(h_q.d2); end
    else if (le_c) begin tr = dab_pkg::TRAJ_R3; dv = 20'(h_q.k) + 20'(3 * 65536); end
    else begin tr = dab_pkg::TRAJ_R4; dv = 20'(h_q.k) << 1; nm = n4; end
  end
  // 2*D2 - one always fits 24 signed bits
  assign n4s = n4[23:0];
  // R4 needs n4*(k+S): multiply here, stage I
  logic signed [47:0] m4_q; logic r4_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) i_v_q <= 1'b0;
    else if (en) i_v_q <= h_v_q;
  end
  always_ff @(posedge clk_i) if (en) begin
    i_q.c <= h_q; i_q.traj <= tr;
    i_q.neg <= 1'b0;
    inum_q <= nm; iden_q <= dv;
    m4_q <= 48'(n4s * signed'({1'b0, 20'(h_q.k) + 20'd65536}));
    r4_q <= (tr == dab_pkg::TRAJ_R4);
  end

  // stage J: magnitude for floor division
  dtag_t j_q; logic j_v_q; logic [46:0] jmag_q; logic [19:0] jden_q; dtag_t j_d;
  logic signed [47:0] jn;
  assign jn = r4_q ? m4_q : inum_q;
  always_comb begin
    j_d = i_q;
    j_d.neg = jn[47];
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) j_v_q <= 1'b0;
    else if (en) j_v_q <= i_v_q;
  end
  always_ff @(posedge clk_i) if (en) begin
    j_q <= j_d;
    jmag_q <= jn[47] ? 47'(-jn - 48'sd1) : jn[46:0];
    jden_q <= iden_q;
  end

  // D1 divider; floor of negative n is -(((-n-1)/d)+1)
  logic dv_o; logic [46:0] dq; logic [TW-1:0] dt;
  dab_divider #(.NumW(47), .DenW(20), .TagW(TW)) u_ddiv (
    .clk_i, .rst_ni, .en_i(en), .valid_i(j_v_q), .num_i(jmag_q),
    .den_i(jden_q), .tag_i(j_q), .valid_o(dv_o), .quo_o(dq), .tag_o(dt));

  // stage K: overflow, clamp, assemble result
  dtag_t ko; logic signed [48:0] q; logic signed [48:0] lim; logic signed [48:0] d1;
  logic [6:0] fl; logic signed [15:0] d1o;
  assign ko = dtag_t'(dt);
  always_comb begin
    lim = 49'sd1 <<< (DW - 1);
    q = ko.neg ? -49'(signed'({2'b0, dq})) - 49'sd1 : 49'(signed'({2'b0, dq}));
    fl = ko.c.flags;
    d1 = q;
    if (q >= lim || q < -lim) begin fl[5] = 1'b1; d1 = '0; end
    if (d1 < 49'(cfg.d1_lo)) d1o = cfg.d1_lo;
    else if (d1 > 49'(cfg.d1_hi)) d1o = cfg.d1_hi;
    else d1o = d1[15:0];
    if (49'(d1o) != d1) fl[6] = 1'b1;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_if.valid <= 1'b0;
    else if (en) out_if.valid <= dv_o;
  end
  always_ff @(posedge clk_i) if (en) begin
    if (ko.c.early) begin
      out_if.inner_duty <= '0; out_if.outer_duty_used <= '0;
      out_if.trajectory <= dab_pkg::TRAJ_NONE; out_if.error_bits <= 7'd1;
      out_if.voltage_ratio <= '0; out_if.load_fraction <= '0; out_if.base_power <= '0;
    end else if (ko.c.pnsm) begin
      out_if.inner_duty <= '0; out_if.outer_duty_used <= '0;
      out_if.trajectory <= dab_pkg::TRAJ_NONE;
      out_if.error_bits <= {4'b0, 1'b1, ko.c.flags[1], 1'b0};
      out_if.voltage_ratio <= ko.c.k; out_if.load_fraction <= '0;
      out_if.base_power <= ko.c.pn;
    end else begin
      out_if.inner_duty <= d1o; out_if.outer_duty_used <= ko.c.d2;
      out_if.trajectory <= ko.traj; out_if.error_bits <= fl;
      out_if.voltage_ratio <= ko.c.k; out_if.load_fraction <= ko.c.p;
      out_if.base_power <= ko.c.pn;
    end
  end

  `DAB_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, out_if.valid && !out_if.ready, out_if.valid)
  `DAB_ASSERT_IMP(a_ready_free, clk_i, rst_ni, !out_if.valid, in_if.ready)
  `DAB_ASSERT_IMP(a_traj_set, clk_i, rst_ni, out_if.valid && out_if.error_bits[0],
    out_if.trajectory == dab_pkg::TRAJ_NONE)
endmodule
